### hw/rtl/agc_pkg.sv
// Package with shared types and constants of the anagram group classifier.
`default_nettype none
package agc_pkg;
  localparam int MaxLenDefault    = 16;
  localparam int MaxGroupsDefault = 64;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_LONG = 2'd2;

  typedef struct packed {
    logic [7:0] char_code;
    logic       has_char;
    logic       last_char;
    logic       start_set;
  } agc_in_t;

  typedef struct packed {
    logic [5:0]  group_index;
    logic [15:0] position_in_group;
    logic        new_group;
    logic [6:0]  group_count;
    logic [1:0]  status;
  } agc_out_t;
endpackage
`default_nettype wire

### hw/rtl/agc_ram.sv
// Generic single-port RAM with a registered read.
`default_nettype none
module agc_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

### hw/rtl/agc_sort_cell.sv
// One cell of the insertion-sort chain: holds one key byte.
`default_nettype none
module agc_sort_cell (
  input  wire logic       clk,
  input  wire logic       clear,
  input  wire logic       ins,
  input  wire logic [7:0] new_char,
  input  wire logic       left_valid,
  input  wire logic       left_gt,
  input  wire logic [7:0] left_char,
  output logic            valid,
  output logic            gt,
  output logic [7:0]      key_char
);
  // A cell shifts its left neighbor's byte in when that neighbor exceeds the new byte,
  // takes the new byte if it is the insertion point, and otherwise keeps its byte.
  assign gt = valid && (key_char > new_char);
  always_ff @(posedge clk) begin
    if (clear) begin
      valid <= 1'b0;
    end else if (ins) begin
      if (left_gt) begin
        key_char <= left_char;
        valid    <= 1'b1;
      end else if (!valid || gt) begin
        // Only the cell right after the filled run, or one holding a larger
        // byte, is the insertion point; cells past the run stay empty.
        if (left_valid) begin
          key_char <= new_char;
          valid    <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### hw/rtl/anagram_group_classifier_core.sv
// Top level of the anagram group classifier core.
`default_nettype none
// Strings arrive one character word per start pulse. Each word is inserted into a
// chain of MAX_LEN sort cells without leaving the idle state, so busy stays low
// between characters of a string. At the end of a string the core walks the stored
// groups in order: S_HEAD addresses the group's key length and size, S_HWAIT reads
// them, and S_CMP compares the key byte by byte through the key RAM. When a group
// matches, S_UPD then updates its size. A string that opens a new group has its key
// copied into the key RAM in S_COPY before S_UPD; with a full table no key is copied
// and no size is written. A too-long string answers in the cycle after its end word
// without raising busy. The result strobe (done) is high for one cycle and the
// receiver cannot stall it. No clearing pass is needed: only groups below the group
// count are ever read.
module anagram_group_classifier_core
  import agc_pkg::*;
#(
  parameter int MAX_LEN    = MaxLenDefault,
  parameter int MAX_GROUPS = MaxGroupsDefault
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire agc_in_t  in_word,
  output logic          busy,
  output logic          done,
  output agc_out_t      result
);
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int LI = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int CW = $clog2(MAX_GROUPS + 1);
  localparam int KD = MAX_GROUPS * MAX_LEN;
  localparam int KW = $clog2(KD);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_HEAD  = 6'b000010,
    S_HWAIT = 6'b000100,
    S_CMP   = 6'b001000,
    S_COPY  = 6'b010000,
    S_UPD   = 6'b100000
  } state_t;

  state_t state;
  logic [LW-1:0] key_length;
  logic          key_overflow;
  logic [CW-1:0] group_total;
  logic [GW-1:0] grp;
  logic [LW-1:0] idx;
  logic [LW-1:0] rd_cnt;
  logic          match;

  wire accept = start && !busy;
  wire clr_start = accept && in_word.start_set && key_length == '0 && !key_overflow;
  wire do_ins = accept && in_word.has_char && key_length < LW'(MAX_LEN);
  wire do_end = accept && in_word.last_char;

  // Sort chain.
  logic [MAX_LEN-1:0] cv, cg;
  logic [7:0] cc [MAX_LEN];
  logic chain_clear;
  genvar i;
  generate
    for (i = 0; i < MAX_LEN; i++) begin : g_cell
      agc_sort_cell u_cell (
        .clk(clk), .clear(chain_clear), .ins(do_ins), .new_char(in_word.char_code),
        .left_valid((i == 0) ? 1'b1 : cv[(i == 0) ? 0 : i-1]),
        .left_gt((i == 0) ? 1'b0 : cg[(i == 0) ? 0 : i-1]),
        .left_char((i == 0) ? 8'd0 : cc[(i == 0) ? 0 : i-1]),
        .valid(cv[i]), .gt(cg[i]), .key_char(cc[i]));
    end
  endgenerate

  // Group memories.
  logic          len_we, size_we, key_we;
  logic [LW-1:0] len_rd;
  logic [15:0]   size_rd, size_wd;
  logic [7:0]    key_rd;
  logic [KW-1:0] key_addr;
  logic [GW-1:0] tbl_addr;
  logic [LI-1:0] ci;

  assign ci = (state == S_COPY) ? idx[LI-1:0] : rd_cnt[LI-1:0];
  assign key_addr = KW'(grp) * KW'(MAX_LEN) + KW'(ci);
  assign tbl_addr = grp;

  agc_ram #(.Width(LW), .Depth(MAX_GROUPS)) u_len (
    .clk(clk), .we(len_we), .addr(tbl_addr), .wdata(key_length), .rdata(len_rd));
  agc_ram #(.Width(16), .Depth(MAX_GROUPS)) u_size (
    .clk(clk), .we(size_we), .addr(tbl_addr), .wdata(size_wd), .rdata(size_rd));
  agc_ram #(.Width(8), .Depth(KD)) u_key (
    .clk(clk), .we(key_we), .addr(key_addr), .wdata(cc[ci]), .rdata(key_rd));

  assign busy = (state != S_IDLE);
  assign chain_clear = rst || (state == S_UPD) || (do_end && (key_overflow ||
                       (in_word.has_char && key_length == LW'(MAX_LEN))));
  assign len_we  = (state == S_COPY) && idx == '0;
  assign key_we  = (state == S_COPY) && idx < key_length;
  // The full-table exit passes S_UPD with a nonzero status and writes no size.
  assign size_we = (state == S_UPD) && (result.status == STATUS_OK);
  wire last_grp = (CW'(grp) + 1'b1 == group_total);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      key_length   <= '0;
      key_overflow <= 1'b0;
      group_total  <= '0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (clr_start) group_total <= '0;
          if (accept && in_word.has_char) begin
            if (key_length < LW'(MAX_LEN)) key_length <= key_length + 1'b1;
            else key_overflow <= 1'b1;
          end
          if (do_end) begin
            grp    <= '0;
            result <= '0;
            result.group_count <= 7'(clr_start ? '0 : group_total);
            if (key_overflow || (in_word.has_char && key_length == LW'(MAX_LEN))) begin
              result.status <= STATUS_LONG;
              done          <= 1'b1;
              key_length    <= '0;
              key_overflow  <= 1'b0;
            end else if (clr_start || group_total == '0) begin
              idx   <= '0;
              state <= S_COPY;
            end else begin
              state <= S_HEAD;
            end
          end
        end
        S_HEAD: begin
          rd_cnt <= '0;
          state  <= S_HWAIT;
        end
        S_HWAIT: begin
          // Length and size of the group are now on the RAM outputs.
          match  <= (len_rd == key_length);
          rd_cnt <= rd_cnt + 1'b1;
          idx    <= '0;
          state  <= S_CMP;
        end
        S_CMP: begin
          if (idx < key_length && key_rd != cc[idx[LI-1:0]]) match <= 1'b0;
          if (rd_cnt < LW'(MAX_LEN - 1)) rd_cnt <= rd_cnt + 1'b1;
          idx <= idx + 1'b1;
          if (idx == LW'(MAX_LEN - 1)) begin
            if (match && !(idx < key_length && key_rd != cc[idx[LI-1:0]])) begin
              state <= S_UPD;
            end else if (!last_grp) begin
              grp   <= grp + 1'b1;
              state <= S_HEAD;
            end else if (group_total < CW'(MAX_GROUPS)) begin
              grp   <= GW'(group_total);
              idx   <= '0;
              state <= S_COPY;
            end else begin
              result.status <= STATUS_FULL;
              done          <= 1'b1;
              key_length    <= '0;
              state         <= S_UPD;
              match         <= 1'b0;
            end
          end
        end
        S_COPY: begin
          idx <= idx + 1'b1;
          if (idx == LW'(MAX_LEN - 1)) begin
            match <= 1'b0;
            group_total <= group_total + 1'b1;
            result.group_index <= 6'(grp);
            result.new_group   <= 1'b1;
            result.group_count <= 7'(group_total + 1'b1);
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (match) begin
            result.group_index       <= 6'(grp);
            result.position_in_group <= size_rd;
          end
          if (result.status == STATUS_OK) done <= 1'b1;
          key_length   <= '0;
          key_overflow <= 1'b0;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A joining member bumps the size up to saturation; a new group starts at one.
  always_comb begin
    if (match) size_wd = (size_rd == 16'hFFFF) ? size_rd : size_rd + 16'd1;
    else       size_wd = 16'd1;
  end
endmodule
`default_nettype wire

### hw/rtl/agc_checker.sv
// Port-level assertions for the anagram group classifier core, with bind.
`default_nettype none
module agc_checker
  import agc_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     start,
  input wire logic     busy,
  input wire logic     done,
  input wire agc_out_t result
);
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == STATUS_OK || result.status == STATUS_FULL ||
              result.status == STATUS_LONG)) else $error("bad status");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status != STATUS_OK |-> !result.new_group &&
      result.group_index == '0) else $error("error result not zeroed");
  a_new_pos: assert property (@(posedge clk) disable iff (rst)
    done && result.new_group |-> result.position_in_group == '0)
    else $error("new group position");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done longer than one cycle");
  // A result only follows a cycle in which a word was offered or work was going on.
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) || $past(start)) else $error("result without a cause");
endmodule
bind anagram_group_classifier_core agc_checker u_agc_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .result(result));
`default_nettype wire

### verif/anagram_group_classifier_checker.sv
// Checker that predicts and compares the anagram classifier's result words.
`timescale 1ns / 1ps
module anagram_group_classifier_checker
  import agc_pkg::*;
#(
  parameter int MAX_LEN    = MaxLenDefault,
  parameter int MAX_GROUPS = MaxGroupsDefault
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire logic    busy,
  input  wire agc_in_t in_word,
  input  wire logic    done,
  input  wire agc_out_t result,
  output int           fail_count,
  output int           pending
);
  logic [7:0]  sorted_chars [MAX_LEN];
  int          sorted_len;
  bit          too_long;
  logic [7:0]  stored_keys [MAX_GROUPS][MAX_LEN];
  int          stored_lens [MAX_GROUPS];
  int          member_counts [MAX_GROUPS];
  int          groups_used;
  agc_out_t    expected_words [$];

  assign pending = expected_words.size();

  // Advances the classifier state by one accepted word; returns 1 with a result.
  function automatic bit classify_word(input agc_in_t w, output agc_out_t r);
    int p;
    int g;
    bit hit;
    bit same;
    r = '0;
    if (w.start_set && sorted_len == 0 && !too_long) groups_used = 0;
    if (w.has_char) begin
      if (sorted_len < MAX_LEN) begin
        p = sorted_len;
        while (p > 0 && sorted_chars[p-1] > w.char_code) begin
          sorted_chars[p] = sorted_chars[p-1];
          p--;
        end
        sorted_chars[p] = w.char_code;
        sorted_len++;
      end else begin
        too_long = 1;
      end
    end
    if (!w.last_char) return 0;
    if (too_long) begin
      r.status = STATUS_LONG;
    end else begin
      hit = 0;
      for (g = 0; g < groups_used; g++) begin
        same = (stored_lens[g] == sorted_len);
        for (int k = 0; k < sorted_len; k++)
          if (stored_keys[g][k] != sorted_chars[k]) same = 0;
        if (same) begin
          hit = 1;
          break;
        end
      end
      if (hit) begin
        r.group_index = g[5:0];
        r.position_in_group = member_counts[g][15:0];
        if (member_counts[g] < 65535) member_counts[g]++;
      end else if (groups_used < MAX_GROUPS) begin
        for (int k = 0; k < sorted_len; k++) stored_keys[groups_used][k] = sorted_chars[k];
        stored_lens[groups_used] = sorted_len;
        member_counts[groups_used] = 1;
        r.group_index = groups_used[5:0];
        r.new_group = 1'b1;
        groups_used++;
      end else begin
        r.status = STATUS_FULL;
      end
    end
    r.group_count = groups_used[6:0];
    sorted_len = 0;
    too_long = 0;
    return 1;
  endfunction

  always @(posedge clk) begin
    agc_out_t want;
    agc_out_t got;
    if (rst) begin
      sorted_len  <= 0;
      too_long    <= 0;
      groups_used <= 0;
      fail_count  <= 0;
      expected_words.delete();
    end else begin
      // Results are checked before new words are predicted: a result cannot
      // belong to a word accepted on the same edge.
      if (done) begin
        got = result;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected idx=%0d pos=%0d new=%0d cnt=%0d st=%0d",
                     $time, want.group_index, want.position_in_group, want.new_group,
                     want.group_count, want.status);
            $display("%0t:          actual   idx=%0d pos=%0d new=%0d cnt=%0d st=%0d",
                     $time, got.group_index, got.position_in_group, got.new_group,
                     got.group_count, got.status);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        if (classify_word(in_word, want)) expected_words.push_back(want);
      end
    end
  end
endmodule

### verif/anagram_group_classifier_core_tb.sv
// Testbench top that drives character words into the classifier and gives the verdict.
`timescale 1ns / 1ps
module anagram_group_classifier_core_tb;
  import agc_pkg::*;

  logic     clk;
  logic     rst;
  logic     start;
  agc_in_t  in_word;
  logic     busy;
  logic     done;
  agc_out_t result;
  int       fail_count;
  int       pending;
  longint   cycle_count;

  // A worst-case end of string walks all 64 groups and then copies a key; even if
  // every word were the end of a string, with the longest gaps the run stays several
  // times below this limit.
  localparam longint CycleLimit = 20000000;

  anagram_group_classifier_core DUT (
    .clk(clk), .rst(rst), .start(start), .in_word(in_word),
    .busy(busy), .done(done), .result(result)
  );

  anagram_group_classifier_checker checker_inst (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_word(in_word),
    .done(done), .result(result), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // The run is cut off if it hangs.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Mostly short gaps, now and then a long one, and often none at all.
  function automatic int gap_len();
    return ($urandom_range(0, 9) < 5) ? 0 :
           ($urandom_range(0, 9) < 8) ? int'($urandom_range(1, 3)) :
                                        int'($urandom_range(10, 40));
  endfunction

  // Presents one word and holds it until the core takes it. Start is dropped
  // only when a real gap follows, so it never toggles within one step.
  task automatic send_word(input logic [7:0] c, input bit has, input bit last,
                           input bit clear_set);
    agc_in_t w;
    int n;
    w.char_code = c;
    w.has_char  = has;
    w.last_char = last;
    w.start_set = clear_set;
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    if ($urandom_range(0, 9) < 5) begin
      n = gap_len();
      if (n > 0) begin
        start   <= 1'b0;
        in_word <= agc_in_t'(11'($urandom));
        repeat (n) @(posedge clk);
      end
    end
  endtask

  // Sends a whole string; its characters are given in the queue.
  task automatic send_string(input logic [7:0] chars [$], input bit clear_set);
    int n;
    n = chars.size();
    if (n == 0) begin
      send_word(8'($urandom), 1'b0, 1'b1, clear_set);
    end else begin
      for (int i = 0; i < n; i++) begin
        // Occasionally a word without a character sits inside the string.
        if (i > 0 && $urandom_range(0, 19) == 0)
          send_word(8'($urandom), 1'b0, 1'b0, 1'($urandom_range(0, 1)));
        send_word(chars[i], 1'b1, i == n - 1,
                  (i == 0) ? clear_set : 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Shuffles a key into a new anagram of itself.
  function automatic void shuffle_chars(ref logic [7:0] chars [$]);
    logic [7:0] t;
    int j;
    for (int i = chars.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = chars[i];
      chars[i] = chars[j];
      chars[j] = t;
    end
  endfunction

  initial begin
    logic [7:0] chars [$];
    logic [7:0] pool [$][$];
    logic [7:0] base [$];
    int words_sent;
    int n;
    start   <= 1'b0;
    in_word <= '0;
    rst     <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty strings, extreme bytes, anagrams, a too-long string,
    // a zero byte, and a clear of the table.
    chars = {};                         send_string(chars, 1'b0);
    chars = {};                         send_string(chars, 1'b0);
    chars = {8'h00};                    send_string(chars, 1'b0);
    chars = {8'hFF, 8'h00, 8'h80};      send_string(chars, 1'b0);
    chars = {8'h80, 8'hFF, 8'h00};      send_string(chars, 1'b0);
    chars = {8'h55, 8'hAA};             send_string(chars, 1'b0);
    chars = {};
    for (int i = 0; i < 16; i++) chars.push_back(8'(15 - i));
    send_string(chars, 1'b0);
    chars.push_back(8'h7F);             send_string(chars, 1'b0);
    chars = {8'hAA, 8'h55};             send_string(chars, 1'b1);
    // A start flag on a mid-string word must be ignored.
    send_word(8'h01, 1'b1, 1'b0, 1'b0);
    send_word(8'h02, 1'b1, 1'b1, 1'b1);
    // Fill the table past its capacity to reach the table-full status.
    for (int g = 0; g < 66; g++) begin
      chars = {8'(g), 8'hC3};
      send_string(chars, 1'b0);
    end
    chars = {8'hC3, 8'd5};              send_string(chars, 1'b0);

    // Random part: mostly anagrams of a few live keys, a clear now and then.
    words_sent = 0;
    while (words_sent < 2000) begin
      if (pool.size() == 0 || $urandom_range(0, 9) < 3) begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 20) :
            ($urandom_range(0, 9) == 0) ? 16 : $urandom_range(0, 6);
        base = {};
        for (int i = 0; i < n; i++)
          base.push_back(($urandom_range(0, 1)) ? 8'($urandom) : 8'($urandom_range(0, 3)));
        if (pool.size() > 20) pool.delete(0);
        pool.push_back(base);
      end
      chars = pool[$urandom_range(0, pool.size() - 1)];
      shuffle_chars(chars);
      send_string(chars, $urandom_range(0, 59) == 0);
      words_sent += chars.size() + 1;
    end

    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    // The last string may still be finishing its walk of the table.
    repeat (2000) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
